// ----- rtl/rscf_pkg.sv -----
// Package for the radar sensor command framer: codes, frame constants and command helpers.
package rscf_pkg;

	localparam int unsigned FrameLen  = 7;
	localparam int unsigned StoreLen  = 6;
	localparam int unsigned IdxW      = 3;

	localparam logic [7:0] HeadA     = 8'h55;
	localparam logic [7:0] HeadB     = 8'h5A;
	localparam logic [7:0] TailByte  = 8'hFE;
	localparam logic [7:0] EnableOn  = 8'h01;
	localparam logic [15:0] DistMax  = 16'd15;
	localparam logic [15:0] LightMax = 16'd1023;

	localparam logic [IdxW-1:0] LastIdx  = IdxW'(FrameLen - 1);
	localparam logic [IdxW-1:0] StoreTop = IdxW'(StoreLen);

	typedef enum logic [1:0] {
		KIND_TX     = 2'd0,
		KIND_ENABLE = 2'd1,
		KIND_LEVEL  = 2'd2,
		KIND_VALUE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		OP_RADAR_GET = 4'd0,
		OP_RADAR_SET = 4'd1,
		OP_DIST_GET  = 4'd2,
		OP_DIST_SET  = 4'd3,
		OP_LEN_GET   = 4'd4,
		OP_LEN_SET   = 4'd5,
		OP_LHI_GET   = 4'd6,
		OP_LHI_SET   = 4'd7,
		OP_LLO_GET   = 4'd8,
		OP_LLO_SET   = 4'd9
	} op_t;

	localparam logic [7:0] CmdRadarGet = 8'h89;
	localparam logic [7:0] CmdRadarSet = 8'h09;
	localparam logic [7:0] CmdDistGet  = 8'h81;
	localparam logic [7:0] CmdDistSet  = 8'h01;
	localparam logic [7:0] CmdLenGet   = 8'h83;
	localparam logic [7:0] CmdLenSet   = 8'h03;
	localparam logic [7:0] CmdLhiGet   = 8'h84;
	localparam logic [7:0] CmdLhiSet   = 8'h04;
	localparam logic [7:0] CmdLloGet   = 8'h85;
	localparam logic [7:0] CmdLloSet   = 8'h05;

	function automatic logic [7:0] op_cmd(input logic [3:0] op);
		logic [7:0] cmd;
		unique case (op)
			OP_RADAR_GET: cmd = CmdRadarGet;
			OP_RADAR_SET: cmd = CmdRadarSet;
			OP_DIST_GET:  cmd = CmdDistGet;
			OP_DIST_SET:  cmd = CmdDistSet;
			OP_LEN_GET:   cmd = CmdLenGet;
			OP_LEN_SET:   cmd = CmdLenSet;
			OP_LHI_GET:   cmd = CmdLhiGet;
			OP_LHI_SET:   cmd = CmdLhiSet;
			OP_LLO_GET:   cmd = CmdLloGet;
			OP_LLO_SET:   cmd = CmdLloSet;
			default:      cmd = 8'h00;
		endcase
		return cmd;
	endfunction

	function automatic kind_t cmd_kind(input logic [7:0] cmd);
		kind_t k;
		unique case (cmd)
			CmdRadarGet, CmdRadarSet, CmdLenGet, CmdLenSet:   k = KIND_ENABLE;
			CmdDistGet, CmdDistSet:                           k = KIND_LEVEL;
			CmdLhiGet, CmdLhiSet, CmdLloGet, CmdLloSet:       k = KIND_VALUE;
			default:                                          k = KIND_TX;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/radar_sensor_command_framer_unit.sv -----
// Top level of the radar sensor command framer: send framing and receive decoding.
//
// channel  | handshake                    | payload
// ---------+------------------------------+-----------------------------------------------
// request  | item_valid / item_ready      | req_type, rx_byte, request_op, request_arg
// result   | result_valid / result_ready  | report_kind, tx_byte, last_byte, enabled_flag,
//          |                              | level_value, light_value
//
// A received byte passes the input register and leaves at most one report in the result
// register; one byte per cycle is sustained while the result register is not stalled.
// A send request holds the input register for seven frame bytes, one per unstalled cycle.
// A stalled result register holds the input register when it has a result to load; a new
// request enters as the held one leaves. Reset clears both valid flags, count and armed kind.
module radar_sensor_command_framer_unit
	import rscf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        req_type,
	input  logic [7:0]  rx_byte,
	input  logic [3:0]  request_op,
	input  logic [15:0] request_arg,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  report_kind,
	output logic [7:0]  tx_byte,
	output logic        last_byte,
	output logic        enabled_flag,
	output logic [7:0]  level_value,
	output logic [15:0] light_value
);

	logic            valid_s1;
	logic            req_s1;
	logic [7:0]      rx_s1;
	logic [3:0]      op_s1;
	logic [15:0]     arg_s1;
	logic [IdxW-1:0] idx_q;

	logic [7:0]      frame_q [StoreLen];
	logic [IdxW-1:0] count_q;
	kind_t           armed_q;

	kind_t           kind_q;
	logic [7:0]      tx_q;
	logic            last_q;
	logic            en_q;
	logic [7:0]      lvl_q;
	logic [15:0]     val_q;

	logic            out_space;
	logic            has_result;
	logic            s1_done;
	logic            out_load;

	logic            op_ok;
	logic [7:0]      cmd;
	logic [7:0]      hi;
	logic [7:0]      lo;
	logic [9:0]      light_clamp;
	logic [7:0]      tx_sel;

	logic [7:0]      rcmd;
	logic [7:0]      rhi;
	logic [7:0]      rlo;
	kind_t           rkind;
	logic            frame_end;
	logic            rx_hit;

	logic            n_en;
	logic [7:0]      n_lvl;
	logic [15:0]     n_val;
	kind_t           n_kind;

	// send path
	always_comb begin
		op_ok = (op_s1 <= OP_LLO_SET);
		cmd = op_cmd(op_s1);
		hi = 8'h00;
		lo = 8'h00;
		light_clamp = (arg_s1 > LightMax) ? LightMax[9:0] : arg_s1[9:0];
		if (op_s1[0]) begin
			priority if (op_s1 == OP_RADAR_SET || op_s1 == OP_LEN_SET) begin
				lo = (arg_s1 != 16'd0) ? EnableOn : 8'h00;
			end else if (op_s1 == OP_DIST_SET) begin
				lo = (arg_s1 > DistMax) ? DistMax[7:0] : arg_s1[7:0];
			end else begin
				hi = {6'd0, light_clamp[9:8]};
				lo = light_clamp[7:0];
			end
		end
		unique case (idx_q)
			3'd0:    tx_sel = HeadA;
			3'd1:    tx_sel = HeadB;
			3'd2:    tx_sel = cmd;
			3'd3:    tx_sel = hi;
			3'd4:    tx_sel = lo;
			3'd5:    tx_sel = cmd ^ hi ^ lo;
			default: tx_sel = TailByte;
		endcase
	end

	// receive path
	always_comb begin
		rcmd = frame_q[2];
		rhi = frame_q[3];
		rlo = frame_q[4];
		rkind = cmd_kind(rcmd);
		frame_end = (count_q == StoreTop);
		rx_hit = frame_end && (rx_s1 == TailByte) && (frame_q[5] == (rcmd ^ rhi ^ rlo))
			&& (rkind != KIND_TX) && (rkind == armed_q);
	end

	always_comb begin
		has_result = req_s1 ? op_ok : rx_hit;
		out_space = !result_valid || result_ready;
		out_load = valid_s1 && has_result && out_space;
		s1_done = valid_s1 && (!has_result || (out_space && (!req_s1 || idx_q == LastIdx)));
		item_ready = !valid_s1 || s1_done;
		n_kind = req_s1 ? KIND_TX : rkind;
		n_en = !req_s1 && rkind == KIND_ENABLE && rlo == EnableOn;
		n_lvl = (!req_s1 && rkind == KIND_LEVEL) ? rlo : 8'h00;
		n_val = (!req_s1 && rkind == KIND_VALUE) ? {rhi, rlo} : 16'h0000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= '0;
			count_q <= '0;
			armed_q <= KIND_TX;
			result_valid <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (s1_done) begin
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (s1_done && req_s1 && op_ok) begin
				armed_q <= cmd_kind(cmd);
			end
			if (s1_done && !req_s1) begin
				count_q <= frame_end ? '0 : count_q + 1'b1;
			end
			if (out_load) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			req_s1 <= req_type;
			rx_s1 <= rx_byte;
			op_s1 <= request_op;
			arg_s1 <= request_arg;
		end
		if (s1_done && !req_s1 && !frame_end) begin
			frame_q[count_q] <= rx_s1;
		end
		if (out_load) begin
			kind_q <= n_kind;
			tx_q <= req_s1 ? tx_sel : 8'h00;
			last_q <= req_s1 && idx_q == LastIdx;
			en_q <= n_en;
			lvl_q <= n_lvl;
			val_q <= n_val;
		end
	end

	assign report_kind = kind_q;
	assign tx_byte = tx_q;
	assign last_byte = last_q;
	assign enabled_flag = en_q;
	assign level_value = lvl_q;
	assign light_value = val_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LastIdx) else $error("frame byte index out of range");

	a_idx_owner: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> valid_s1 && req_s1) else $error("byte index moved without a send");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= StoreTop) else $error("receive count out of range");

	a_report_armed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && report_kind != KIND_TX |-> report_kind == armed_q)
		else $error("report issued for a kind not armed");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && req_s1 && idx_q == LastIdx |-> s1_done)
		else $error("send request held after its tail byte");

endmodule
